/* src/rans_pkg.sv */
// Shared constants, types and controller encoding for the rANS encoder core.
`timescale 1ns / 1ps
package rans_pkg;

  localparam int PROB_BITS   = 12;
  localparam int STATE_W     = 32;
  localparam int FREQ_W      = 13;
  localparam int CUM_W       = 12;
  localparam int TOKEN_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 3;
  localparam int DIV_CNT_W   = $clog2(STATE_W);
  localparam int RENORM_BITS = 16;

  localparam logic [STATE_W-1:0]   RESET_STATE = STATE_W'(65536);
  localparam logic [FREQ_W-1:0]    FREQ_FULL   = FREQ_W'(1) << PROB_BITS;
  localparam logic [FREQ_W-1:0]    FREQ_MIN    = FREQ_W'(1);
  localparam logic [IDX_W-1:0]     IDX_RENORM_LAST = IDX_W'(1);
  localparam logic [IDX_W-1:0]     IDX_FLUSH_LAST  = IDX_W'(5);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(STATE_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic div_init;
    logic div_step;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic renorm;
    logic out_free;
    logic byte_last;
    logic div_last;
  } status_t;

endpackage

/* src/rans_ctrl.sv */
// Controller state machine sequencing request capture, byte emission, division and update.
`timescale 1ns / 1ps
module rans_ctrl
  import rans_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.kind || status.renorm) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take a byte
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.byte_last) begin
            state_nxt = status.kind ? ST_UPDATE : ST_DIV_INIT;
          end
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/rans_dp.sv */
// Datapath: request registers, coder state, bit-serial divider and output register.
`timescale 1ns / 1ps
module rans_dp
  import rans_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_kind,
  input  logic [FREQ_W-1:0]  in_freq,
  input  logic [CUM_W-1:0]   in_cum_freq,
  input  logic [TOKEN_W-1:0] in_raw_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  input  cmd_t               cmd,
  output status_t            status
);

  logic                 kind_r;
  logic [FREQ_W-1:0]    freq_r;
  logic [CUM_W-1:0]     cum_r;
  logic [TOKEN_W-1:0]   raw_r;
  logic [STATE_W-1:0]   st_r;
  logic [STATE_W-1:0]   quo_r;
  logic [PROB_BITS-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;

  logic [FREQ_W-1:0]    freq_clamped;
  logic [STATE_W:0]     threshold;
  logic                 renorm;
  logic                 byte_last;
  logic [BYTE_W-1:0]    byte_sel;
  logic [FREQ_W-1:0]    rem_shift;
  logic                 rem_ge;
  logic [PROB_BITS-1:0] rem_nxt;
  logic [STATE_W-1:0]   st_nxt;

  // zero frequency counts as one; anything above full scale saturates
  always_comb begin
    if (in_freq == '0) begin
      freq_clamped = FREQ_MIN;
    end else if (in_freq > FREQ_FULL) begin
      freq_clamped = FREQ_FULL;
    end else begin
      freq_clamped = in_freq;
    end
  end

  assign threshold = {freq_r, {(STATE_W + 1 - FREQ_W){1'b0}}};
  assign renorm    = {1'b0, st_r} >= threshold;
  assign byte_last = kind_r ? (idx_r == IDX_FLUSH_LAST) : (idx_r == IDX_RENORM_LAST);

  always_comb begin
    case (idx_r)
      3'd0:    byte_sel = st_r[7:0];
      3'd1:    byte_sel = st_r[15:8];
      3'd2:    byte_sel = st_r[23:16];
      3'd3:    byte_sel = st_r[31:24];
      3'd4:    byte_sel = raw_r[7:0];
      3'd5:    byte_sel = raw_r[15:8];
      default: byte_sel = '0;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign rem_shift = {rem_r, quo_r[STATE_W-1]};
  assign rem_ge    = rem_shift >= freq_r;
  assign rem_nxt   = rem_ge ? PROB_BITS'(rem_shift - freq_r) : rem_shift[PROB_BITS-1:0];

  assign st_nxt = {quo_r[STATE_W-PROB_BITS-1:0], {PROB_BITS{1'b0}}}
                + STATE_W'(rem_r) + STATE_W'(cum_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      freq_r <= freq_clamped;
      cum_r  <= in_cum_freq;
      raw_r  <= in_raw_token;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RESET_STATE;
    end else if (cmd.update) begin
      st_r <= kind_r ? RESET_STATE : st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r     <= renorm ? (st_r >> RENORM_BITS) : st_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[STATE_W-2:0], rem_ge};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= byte_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign status.kind      = kind_r;
  assign status.renorm    = renorm;
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.byte_last = byte_last;
  assign status.div_last  = (div_cnt_r == DIV_LAST);

endmodule

/* src/rans_encoder_step_core.sv */
// rANS encoder step core: 32-bit coder state, 16-bit renormalization, flush with raw token.
// Encode request, from accept to ready: accept, load, two byte slots with renormalization only,
// divider setup, bit-serial divider, state update.
// Flush request: accept, load, six byte slots, update; output stalls stretch the byte slots of both.
// One request at a time; the shift-subtract divider sets the encode rate.
// Synchronous active-low reset sets the coder state to 65536 and empties the output register.
`timescale 1ns / 1ps
module rans_encoder_step_core
  import rans_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [FREQ_W-1:0]  in_freq,
  input  logic [CUM_W-1:0]   in_cum_freq,
  input  logic [TOKEN_W-1:0] in_raw_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  cmd_t    cmd;
  status_t status;

  rans_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rans_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_freq      (in_freq),
    .in_cum_freq  (in_cum_freq),
    .in_raw_token (in_raw_token),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* src/rans_checker.sv */
// Port-level assertions for the rANS encoder core, bound to the top level.
`timescale 1ns / 1ps
module rans_checker
  import rans_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               out_last
);

  // a stalled byte holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output byte changed while stalled");

  // one request at a time: busy right after accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in progress");

  // no byte can appear the cycle after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("byte emitted before request was loaded");

  // reset leaves the core idle with an empty output
  assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("core not idle after reset");

endmodule

bind rans_encoder_step_core rans_checker u_rans_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
